// ----- src/lsra_pkg.sv -----
// ----------------------------------------------------------------------------
// lsra_pkg
// Shared types and codes of the linear-scan register allocator: sequencer
// states, result status codes, web table encodings and register map.
// ----------------------------------------------------------------------------
package lsra_pkg;

  // Sequencer states
  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK,
    S_SCAN,
    S_LAST,
    S_PICK,
    S_ASSIGN,
    S_RESULT
  } state_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_ASSIGNED       = 3'd0,
    ST_SPILL_ASSIGNED = 3'd1,
    ST_NO_REG         = 3'd2,
    ST_END            = 3'd3,
    ST_IGNORED        = 3'd4
  } status_t;

  // Web table entry: bit 6 marks an active web, bits 5:0 hold its register
  localparam int          WS_W          = 7;
  localparam int          WS_ACTIVE_BIT = 6;
  localparam logic [6:0]  WS_UNASSIGNED = 7'd0;
  localparam logic [6:0]  WS_SPILLED    = 7'd1;
  localparam logic [6:0]  WS_ENDED      = 7'd2;

  // Field widths
  localparam int WEB_W  = 8;
  localparam int AREG_W = 5;

  // Register map: word index taken from paddr[2]
  localparam logic       REG_IDX_NUM_REGS = 1'b0;
  localparam logic [5:0] NUM_REGS_RESET   = 6'd32;

  // One result beat
  typedef struct packed {
    logic [WEB_W-1:0]  out_web_id;
    status_t           status;
    logic [AREG_W-1:0] assigned_reg;
    logic              spill_valid;
    logic [WEB_W-1:0]  spilled_web;
  } result_t;

endpackage

// ----- src/lsra_ram.sv -----
// ----------------------------------------------------------------------------
// lsra_ram
// Simple dual-port synchronous RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module lsra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// ----- src/lsra_ctrl.sv -----
// ----------------------------------------------------------------------------
// lsra_ctrl
// Event sequencer: looks up the web table, scans the register file for the
// lowest free register or the cheapest spill victim, and writes back.
// ----------------------------------------------------------------------------
module lsra_ctrl import lsra_pkg::*; #(
  parameter int NUM_WEBS = 256,
  parameter int NUM_REGS = 32,
  parameter int LEN_BITS = 16,
  parameter int WEB_AW   = $clog2(NUM_WEBS),
  parameter int RW       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
  input  logic                      clk,
  input  logic                      rst,
  // Event channel
  input  logic                      item_valid,
  output logic                      item_stall,
  input  logic                      func,
  input  logic [WEB_W-1:0]          web_id,
  input  logic [15:0]               web_length,
  // Configuration
  input  logic [5:0]                num_regs,
  // Web table memory
  output logic                      ws_we,
  output logic [WEB_AW-1:0]         ws_waddr,
  output logic [WS_W-1:0]           ws_wdata,
  output logic [WEB_AW-1:0]         ws_raddr,
  input  logic [WS_W-1:0]           ws_rdata,
  // Register owner memory: {owner, length}
  output logic                      own_we,
  output logic [RW-1:0]             own_waddr,
  output logic [WEB_W+LEN_BITS-1:0] own_wdata,
  output logic [RW-1:0]             own_raddr,
  input  logic [WEB_W+LEN_BITS-1:0] own_rdata,
  // Result hand-off
  output result_t                   res,
  output logic                      res_load,
  input  logic                      out_free
);

  localparam int CW = RW + 1;

  state_t               state, state_next;
  logic [WEB_AW-1:0]    clr_addr;
  logic                 func_q;
  logic [WEB_W-1:0]     web_q;
  logic [LEN_BITS-1:0]  len_q;
  logic [NUM_REGS-1:0]  busy;
  logic [RW-1:0]        scan_idx;
  logic [RW-1:0]        cmp_idx;
  logic                 cmp_vld;
  logic                 have;
  logic [RW-1:0]        best_reg;
  logic [LEN_BITS-1:0]  best_len;
  logic [WEB_W-1:0]     best_owner;
  logic [RW-1:0]        pick;
  logic                 spill;

  logic [CW-1:0]        usable;
  logic                 web_ok;
  logic                 free_hit;
  logic                 scan_last;
  logic                 ws_active;
  logic [5:0]           ws_reg;
  logic [WEB_W-1:0]     own_owner;
  logic [LEN_BITS-1:0]  own_len;
  logic                 better;

  // Clamp the configured register count
  assign usable    = (32'(num_regs) > NUM_REGS) ? CW'(NUM_REGS) : CW'(num_regs);
  assign web_ok    = (32'(web_id) < NUM_WEBS);
  assign free_hit  = (CW'(scan_idx) < usable) && !busy[scan_idx];
  assign scan_last = (scan_idx == RW'(NUM_REGS - 1));
  assign ws_active = ws_rdata[WS_ACTIVE_BIT];
  assign ws_reg    = ws_rdata[5:0];
  assign own_owner = own_rdata[LEN_BITS +: WEB_W];
  assign own_len   = own_rdata[LEN_BITS-1:0];

  // Spill candidate compare: fewer points first, then lower web id
  assign better = cmp_vld && busy[cmp_idx] &&
                  (!have || (own_len < best_len) ||
                   ((own_len == best_len) && (own_owner < best_owner)));

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_addr == WEB_AW'(NUM_WEBS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (item_valid) state_next = web_ok ? S_LOOK : S_RESULT;
      end
      S_LOOK: begin
        if (func_q && (ws_rdata == WS_UNASSIGNED)) state_next = S_SCAN;
        else state_next = S_RESULT;
      end
      S_SCAN: begin
        if (free_hit) state_next = S_ASSIGN;
        else if (scan_last) state_next = S_LAST;
      end
      S_LAST: begin
        state_next = S_PICK;
      end
      S_PICK: begin
        state_next = have ? S_ASSIGN : S_RESULT;
      end
      S_ASSIGN: begin
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Memory controls and handshake
  always_comb begin
    item_stall = (state != S_IDLE);
    res_load   = 1'b0;
    ws_we      = 1'b0;
    ws_waddr   = WEB_AW'(web_q);
    ws_wdata   = WS_UNASSIGNED;
    ws_raddr   = WEB_AW'(web_id);
    own_we     = 1'b0;
    own_waddr  = pick;
    own_wdata  = {web_q, len_q};
    own_raddr  = scan_idx;
    case (state)
      S_CLEAR: begin
        ws_we    = 1'b1;
        ws_waddr = clr_addr;
      end
      S_LOOK: begin
        if (!func_q && ws_active) begin
          ws_we    = 1'b1;
          ws_wdata = WS_ENDED;
        end
      end
      S_PICK: begin
        if (have) begin
          ws_we    = 1'b1;
          ws_waddr = WEB_AW'(best_owner);
          ws_wdata = WS_SPILLED;
        end
      end
      S_ASSIGN: begin
        ws_we    = 1'b1;
        ws_wdata = {1'b1, 6'(pick)};
        own_we   = 1'b1;
      end
      S_RESULT: begin
        res_load = out_free;
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_addr <= '0;
      busy     <= '0;
      cmp_vld  <= 1'b0;
      have     <= 1'b0;
    end else begin
      state   <= state_next;
      cmp_vld <= (state == S_SCAN);
      if (state == S_CLEAR) clr_addr <= clr_addr + 1'b1;
      // Release the register of an ending web
      if ((state == S_LOOK) && !func_q && ws_active && (32'(ws_reg) < NUM_REGS)) begin
        busy[RW'(ws_reg)] <= 1'b0;
      end
      if (state == S_ASSIGN) busy[pick] <= 1'b1;
      if (state == S_LOOK) have <= 1'b0;
      else if (better) have <= 1'b1;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if ((state == S_IDLE) && item_valid) begin
      func_q <= func;
      web_q  <= web_id;
      len_q  <= LEN_BITS'(web_length);
      res    <= '{out_web_id: web_id, status: ST_IGNORED, assigned_reg: '0,
                  spill_valid: 1'b0, spilled_web: '0};
    end
    // Advance the scan
    if (state == S_LOOK) scan_idx <= '0;
    else if ((state == S_SCAN) && !scan_last) scan_idx <= scan_idx + 1'b1;
    // Track the cheapest busy register
    if (better) begin
      best_reg   <= cmp_idx;
      best_len   <= own_len;
      best_owner <= own_owner;
    end
    case (state)
      S_LOOK: begin
        if (!func_q) begin
          res.status       <= ST_END;
          res.assigned_reg <= ws_active ? AREG_W'(ws_reg) : '0;
        end
      end
      S_SCAN: begin
        if (free_hit) begin
          pick  <= scan_idx;
          spill <= 1'b0;
        end
      end
      S_PICK: begin
        pick  <= best_reg;
        spill <= 1'b1;
        if (!have) res.status <= ST_NO_REG;
      end
      S_ASSIGN: begin
        res.status       <= spill ? ST_SPILL_ASSIGNED : ST_ASSIGNED;
        res.assigned_reg <= AREG_W'(pick);
        res.spill_valid  <= spill;
        res.spilled_web  <= spill ? best_owner : '0;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- src/linear_scan_register_allocator.sv -----
// ----------------------------------------------------------------------------
// linear_scan_register_allocator
// Flow: start events of an unassigned web scan the register owner memory,
// one entry per cycle; end events and ignored starts skip the scan, and a
// web id outside the table also skips the web table lookup.
// One event at a time: the next event is taken in the cycle after its result
// is handed to the output register, which holds it for the consumer.
// Reset: a clearing pass over all NUM_WEBS web table entries marks every web
// unassigned; events are stalled during it, configuration writes are taken.
// ----------------------------------------------------------------------------
module linear_scan_register_allocator import lsra_pkg::*; #(
  parameter int NUM_WEBS = 256,
  parameter int NUM_REGS = 32,
  parameter int LEN_BITS = 16
) (
  input  logic              clk,
  input  logic              rst,
  // Event channel
  input  logic              item_valid,
  output logic              item_stall,
  input  logic              func,
  input  logic [WEB_W-1:0]  web_id,
  input  logic [15:0]       web_length,
  // Result channel
  output logic              result_valid,
  input  logic              result_stall,
  output logic [WEB_W-1:0]  out_web_id,
  output logic [2:0]        status,
  output logic [AREG_W-1:0] assigned_reg,
  output logic              spill_valid,
  output logic [WEB_W-1:0]  spilled_web,
  // Configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int WEB_AW = $clog2(NUM_WEBS);
  localparam int RW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int OWN_W  = WEB_W + LEN_BITS;

  logic [5:0]        num_regs;
  logic              ws_we;
  logic [WEB_AW-1:0] ws_waddr;
  logic [WS_W-1:0]   ws_wdata;
  logic [WEB_AW-1:0] ws_raddr;
  logic [WS_W-1:0]   ws_rdata;
  logic              own_we;
  logic [RW-1:0]     own_waddr;
  logic [OWN_W-1:0]  own_wdata;
  logic [RW-1:0]     own_raddr;
  logic [OWN_W-1:0]  own_rdata;
  result_t           res;
  result_t           out_beat;
  logic              res_load;
  logic              out_free;

  // Configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_IDX_NUM_REGS) ? {26'd0, num_regs} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_regs <= NUM_REGS_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_IDX_NUM_REGS)) begin
      num_regs <= pwdata[5:0];
    end
  end

  // Web status table
  lsra_ram #(
    .WIDTH (WS_W),
    .DEPTH (NUM_WEBS),
    .AW    (WEB_AW)
  ) u_web_mem (
    .clk   (clk),
    .we    (ws_we),
    .waddr (ws_waddr),
    .wdata (ws_wdata),
    .raddr (ws_raddr),
    .rdata (ws_rdata)
  );

  // Register owner and owner length
  lsra_ram #(
    .WIDTH (OWN_W),
    .DEPTH (NUM_REGS),
    .AW    (RW)
  ) u_owner_mem (
    .clk   (clk),
    .we    (own_we),
    .waddr (own_waddr),
    .wdata (own_wdata),
    .raddr (own_raddr),
    .rdata (own_rdata)
  );

  lsra_ctrl #(
    .NUM_WEBS (NUM_WEBS),
    .NUM_REGS (NUM_REGS),
    .LEN_BITS (LEN_BITS),
    .WEB_AW   (WEB_AW),
    .RW       (RW)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .func       (func),
    .web_id     (web_id),
    .web_length (web_length),
    .num_regs   (num_regs),
    .ws_we      (ws_we),
    .ws_waddr   (ws_waddr),
    .ws_wdata   (ws_wdata),
    .ws_raddr   (ws_raddr),
    .ws_rdata   (ws_rdata),
    .own_we     (own_we),
    .own_waddr  (own_waddr),
    .own_wdata  (own_wdata),
    .own_raddr  (own_raddr),
    .own_rdata  (own_rdata),
    .res        (res),
    .res_load   (res_load),
    .out_free   (out_free)
  );

  // Output register: hold the beat until taken
  assign out_free = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) out_beat <= res;
  end

  assign out_web_id   = out_beat.out_web_id;
  assign status       = out_beat.status;
  assign assigned_reg = out_beat.assigned_reg;
  assign spill_valid  = out_beat.spill_valid;
  assign spilled_web  = out_beat.spilled_web;

endmodule

// ----- verif/tb_linear_scan_register_allocator.sv -----
// ----------------------------------------------------------------------------
// tb_linear_scan_register_allocator
// Self-checking bench for the linear-scan register allocator. A queue of
// live-range events feeds a paced driver; a monitor checks every result beat
// against an in-bench allocation predictor over several register counts.
// ----------------------------------------------------------------------------
module tb_linear_scan_register_allocator;
  import lsra_pkg::*;

  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 5;
  localparam int WEB_COUNT      = 256;
  localparam int REG_COUNT      = 32;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_TARGET    = 1330;
  localparam int MAX_REPORTS    = 10;

  // Event kinds on the func field
  localparam logic EV_END   = 1'b0;
  localparam logic EV_START = 1'b1;

  // Configuration addresses: the register count and one unused word
  localparam logic [2:0] ADDR_NUM_REGS = {REG_IDX_NUM_REGS, 2'b00};
  localparam logic [2:0] ADDR_SPARE    = {~REG_IDX_NUM_REGS, 2'b00};

  typedef struct packed {
    logic        fn;
    logic [7:0]  web;
    logic [15:0] len;
  } alloc_event_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              item_valid = 1'b0;
  logic              item_stall;
  logic              func = 1'b0;
  logic [WEB_W-1:0]  web_id = '0;
  logic [15:0]       web_length = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [WEB_W-1:0]  out_web_id;
  logic [2:0]        status;
  logic [AREG_W-1:0] assigned_reg;
  logic              spill_valid;
  logic [WEB_W-1:0]  spilled_web;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [2:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  // Allocator shadow state
  logic [6:0]  web_state [0:WEB_COUNT-1];
  bit          reg_taken [0:REG_COUNT-1];
  logic [7:0]  reg_web   [0:REG_COUNT-1];
  logic [15:0] reg_len   [0:REG_COUNT-1];
  logic [5:0]  alloc_regs = NUM_REGS_RESET;

  alloc_event_t pending_events [$];
  result_t      expected_results [$];
  bit           ever_started [0:WEB_COUNT-1];

  int unsigned events_queued = 0;
  int unsigned results_seen  = 0;
  int unsigned rand_counted  = 0;
  int unsigned mismatches    = 0;
  int unsigned cfg_settings  = 0;
  int unsigned idle_cycles   = 0;
  int unsigned status_hits [0:4];

  bit          ev_taken = 1'b0;
  bit          res_taken = 1'b0;
  int unsigned tx_gap = 0;
  int unsigned rx_hold = 0;
  bit          tx_calm = 1'b0;
  bit          rx_calm = 1'b0;

  linear_scan_register_allocator #(
    .NUM_WEBS(WEB_COUNT),
    .NUM_REGS(REG_COUNT),
    .LEN_BITS(16)
  ) dut (.*);

  always #(CLK_PERIOD / 2) clk = ~clk;

  initial begin
    for (int i = 0; i < WEB_COUNT; i++) begin
      web_state[i] = WS_UNASSIGNED;
      ever_started[i] = 1'b0;
    end
    for (int r = 0; r < REG_COUNT; r++) begin
      reg_taken[r] = 1'b0;
      reg_web[r] = '0;
      reg_len[r] = '0;
    end
    for (int s = 0; s < 5; s++) status_hits[s] = 0;
  end

  function automatic void flag_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_REPORTS) $display("MISMATCH %0d at %0t: %s", mismatches, $time, msg);
  endfunction

  function automatic void hand_over(input int r, input logic [7:0] web, input logic [15:0] len);
    reg_taken[r] = 1'b1;
    reg_web[r] = web;
    reg_len[r] = len;
    web_state[web] = 7'(1 << WS_ACTIVE_BIT) | 7'(r);
  endfunction

  // Apply one event to the shadow state and return the result it must give
  function automatic result_t allocate_event(input logic fn, input logic [7:0] web,
                                             input logic [15:0] len);
    result_t    res;
    logic [6:0] ws;
    int         lim;
    int         best;
    bit         found;
    res = '0;
    res.out_web_id = web;
    res.status = ST_IGNORED;
    ws = web_state[web];
    if (fn == EV_END) begin
      // Release the register of an active web, else just note the end
      res.status = ST_END;
      if (ws[WS_ACTIVE_BIT]) begin
        reg_taken[ws[4:0]] = 1'b0;
        res.assigned_reg = ws[4:0];
        web_state[web] = WS_ENDED;
      end
    end else if (ws == WS_UNASSIGNED) begin
      found = 1'b0;
      lim = (alloc_regs > REG_COUNT) ? REG_COUNT : int'(alloc_regs);
      for (int r = 0; r < lim && !found; r++) begin
        if (!reg_taken[r]) begin
          hand_over(r, web, len);
          res.status = ST_ASSIGNED;
          res.assigned_reg = 5'(r);
          found = 1'b1;
        end
      end
      if (!found) begin
        // Pick the shortest active web over all registers, lowest id on a tie
        best = -1;
        for (int r = 0; r < REG_COUNT; r++) begin
          if (reg_taken[r] && (best < 0 || reg_len[r] < reg_len[best] ||
              (reg_len[r] == reg_len[best] && reg_web[r] < reg_web[best])))
            best = r;
        end
        if (best < 0) begin
          res.status = ST_NO_REG;
        end else begin
          res.status = ST_SPILL_ASSIGNED;
          res.assigned_reg = 5'(best);
          res.spill_valid = 1'b1;
          res.spilled_web = reg_web[best];
          web_state[reg_web[best]] = WS_SPILLED;
          hand_over(best, web, len);
        end
      end
    end
    status_hits[res.status]++;
    return res;
  endfunction

  function automatic logic [15:0] draw_len(input logic [15:0] tie_len);
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 3));
      1: return 16'hFFFF;
      2: return tie_len;
      3: return 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic push_event(input logic fn, input logic [7:0] web, input logic [15:0] len);
    alloc_event_t ev;
    rand_counted++;
    if (fn == EV_START) ever_started[web] = 1'b1;
    ev.fn = fn;
    ev.web = web;
    ev.len = len;
    pending_events.insert(pending_events.size(), ev);
    events_queued++;
  endtask

  // Wait until every queued event has returned its result
  task automatic drain();
    do @(negedge clk); while (results_seen != events_queued);
  endtask

  // Write a configuration word while idle, then read the register count back
  task automatic set_alloc_regs(input logic [2:0] addr, input logic [5:0] value);
    logic [31:0] data;
    logic [31:0] got;
    drain();
    data = $urandom;
    data[5:0] = value;
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    if (addr == ADDR_NUM_REGS) alloc_regs = value;
    cfg_settings++;
    pwrite <= 1'b0;
    penable <= 1'b0;
    paddr <= ADDR_NUM_REGS;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    if (got !== {26'd0, alloc_regs})
      flag_mismatch($sformatf("register count read back %0h, expected %0h", got, alloc_regs));
  endtask

  // Driver: present queued events at the falling edge, hold a beat until taken
  always @(negedge clk) begin : event_driver
    alloc_event_t nxt;
    if (rst) begin
      item_valid <= 1'b0;
      tx_gap <= 0;
    end else if (!item_valid || ev_taken) begin
      if (tx_gap != 0) begin
        item_valid <= 1'b0;
        tx_gap <= tx_gap - 1;
      end else if (pending_events.size() != 0) begin
        nxt = pending_events.pop_front();
        item_valid <= 1'b1;
        func <= nxt.fn;
        web_id <= nxt.web;
        web_length <= nxt.len;
        tx_gap <= tx_calm ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 39) == 0) tx_calm <= !tx_calm;
      end else begin
        item_valid <= 1'b0;
      end
    end
  end

  // Result stall: a new wait count is drawn each time a result beat is taken
  always @(negedge clk) begin : result_pacer
    int unsigned hold;
    if (rst) begin
      result_stall <= 1'b0;
      rx_hold <= 0;
    end else begin
      hold = rx_hold;
      if (res_taken) begin
        hold = rx_calm ? 0 : $urandom_range(0, 8);
        if ($urandom_range(0, 39) == 0) rx_calm <= !rx_calm;
      end
      // Stall the next edge while waits remain; a waiting beat uses one up
      result_stall <= (hold != 0);
      rx_hold <= (result_valid && hold != 0) ? hold - 1 : hold;
    end
  end

  // Monitor: check taken result beats, predict for taken event beats
  always @(posedge clk) begin : beat_monitor
    result_t want;
    result_t seen;
    bit      ev_now;
    bit      res_now;
    ev_now = 1'b0;
    res_now = 1'b0;
    if (rst) begin
      ev_taken <= 1'b0;
      res_taken <= 1'b0;
    end else begin
      ev_now = item_valid && !item_stall;
      res_now = result_valid && !result_stall;
      if (res_now) begin
        results_seen++;
        seen.out_web_id = out_web_id;
        seen.status = status_t'(status);
        seen.assigned_reg = assigned_reg;
        seen.spill_valid = spill_valid;
        seen.spilled_web = spilled_web;
        if (expected_results.size() == 0) begin
          flag_mismatch($sformatf("result for web %0d with no event pending", out_web_id));
        end else begin
          want = expected_results.pop_front();
          if (seen !== want)
            flag_mismatch($sformatf({"expected web %0d status %0d reg %0d spill %0b/%0d, ",
                                     "got web %0d status %0d reg %0d spill %0b/%0d"},
                                    want.out_web_id, want.status, want.assigned_reg,
                                    want.spill_valid, want.spilled_web,
                                    out_web_id, status, assigned_reg,
                                    spill_valid, spilled_web));
        end
      end
      if (ev_now)
        expected_results.insert(expected_results.size(),
                                allocate_event(func, web_id, web_length));
      ev_taken <= ev_now;
      res_taken <= res_now;
    end
    // Watchdog on handshakes and configuration accesses
    if (ev_now || res_now || (psel && penable)) begin
      idle_cycles = 0;
    end else if (++idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles at %0t", idle_cycles, $time);
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [7:0]  fresh_webs [$];
    logic [7:0]  live_webs [$];
    logic [7:0]  w;
    logic [7:0]  tmp;
    logic [15:0] tie_len;
    int          phase_idx;
    int          n_new;
    int          end_max;
    int          idx;
    int          j;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Two registers: plain grants, spill of the shortest web, dead webs
    set_alloc_regs(ADDR_NUM_REGS, 6'd2);
    push_event(EV_START, 8'd0, 16'hFFFF);
    push_event(EV_START, 8'd255, 16'd0);
    push_event(EV_START, 8'd0, 16'd7);
    push_event(EV_START, 8'd1, 16'd5);
    push_event(EV_START, 8'd255, 16'd3);
    push_event(EV_END, 8'd255, 16'd0);
    push_event(EV_END, 8'd0, 16'd0);
    push_event(EV_END, 8'd0, 16'd0);
    push_event(EV_START, 8'd0, 16'd1);
    push_event(EV_START, 8'd9, 16'd5);
    // Equal lengths: the lower web id loses its register
    push_event(EV_START, 8'd4, 16'd9);
    push_event(EV_END, 8'd4, 16'd0);
    push_event(EV_END, 8'd9, 16'd0);

    // No usable register and nothing to spill: the web stays unassigned
    set_alloc_regs(ADDR_NUM_REGS, 6'd0);
    push_event(EV_START, 8'd10, 16'd3);
    push_event(EV_START, 8'd10, 16'd3);

    // Count above the register file is clamped
    set_alloc_regs(ADDR_NUM_REGS, 6'd63);
    push_event(EV_START, 8'd10, 16'd3);
    push_event(EV_START, 8'd11, 16'd1);
    push_event(EV_START, 8'd12, 16'd2);

    // Lowered count: busy registers above it still take part in the spill
    set_alloc_regs(ADDR_NUM_REGS, 6'd1);
    set_alloc_regs(ADDR_SPARE, 6'd32);
    push_event(EV_START, 8'd13, 16'd100);
    push_event(EV_END, 8'd13, 16'd0);
    push_event(EV_END, 8'd10, 16'd0);
    push_event(EV_END, 8'd12, 16'd0);

    // Shuffle the webs not used yet
    for (int i = 0; i < WEB_COUNT; i++)
      if (!ever_started[i]) fresh_webs.insert(fresh_webs.size(), 8'(i));
    for (int i = fresh_webs.size() - 1; i > 0; i--) begin
      j = $urandom_range(0, i);
      tmp = fresh_webs[i];
      fresh_webs[i] = fresh_webs[j];
      fresh_webs[j] = tmp;
    end

    rand_counted = 0;
    phase_idx = 0;
    while (rand_counted < RAND_TARGET) begin
      case (phase_idx % 6)
        0: set_alloc_regs(ADDR_NUM_REGS, 6'd32);
        1: set_alloc_regs(ADDR_NUM_REGS, 6'd1);
        2: set_alloc_regs(ADDR_NUM_REGS, 6'd63);
        3: set_alloc_regs(ADDR_NUM_REGS, 6'($urandom_range(1, 32)));
        4: set_alloc_regs(ADDR_NUM_REGS, 6'd0);
        default: set_alloc_regs(ADDR_NUM_REGS, 6'($urandom_range(2, 8)));
      endcase
      if (fresh_webs.size() != 0) begin
        // Timeline: at each point the ends go first, then the starts
        n_new = $urandom_range(12, 48);
        end_max = $urandom_range(0, 3);
        tie_len = 16'($urandom_range(0, 15));
        while (n_new > 0 && fresh_webs.size() != 0) begin
          repeat ($urandom_range(0, end_max)) begin
            if (live_webs.size() != 0) begin
              idx = $urandom_range(0, live_webs.size() - 1);
              push_event(EV_END, live_webs[idx], 16'($urandom));
              live_webs.delete(idx);
            end
          end
          repeat ($urandom_range(1, 4)) begin
            if (n_new > 0 && fresh_webs.size() != 0) begin
              w = fresh_webs.pop_front();
              push_event(EV_START, w, draw_len(tie_len));
              live_webs.insert(live_webs.size(), w);
              n_new--;
            end
          end
          // Stray event on any web
          if ($urandom_range(0, 5) == 0) begin
            w = 8'($urandom_range(0, WEB_COUNT - 1));
            if ($urandom_range(0, 1) == 0) begin
              push_event(EV_END, w, 16'($urandom));
            end else begin
              if (!ever_started[w]) live_webs.insert(live_webs.size(), w);
              push_event(EV_START, w, draw_len(tie_len));
            end
          end
        end
        // End part of the live webs, carry the rest into the next setting
        repeat ($urandom_range(0, live_webs.size())) begin
          idx = $urandom_range(0, live_webs.size() - 1);
          push_event(EV_END, live_webs[idx], 16'($urandom));
          live_webs.delete(idx);
        end
      end else begin
        // Every web is used up: close the live ones, then late events
        while (live_webs.size() != 0) push_event(EV_END, live_webs.pop_front(), 16'($urandom));
        repeat (40) begin
          w = 8'($urandom_range(0, WEB_COUNT - 1));
          if ($urandom_range(0, 9) < 7) push_event(EV_END, w, 16'($urandom));
          else push_event(EV_START, w, 16'($urandom));
        end
      end
      phase_idx++;
    end

    drain();
    repeat (REG_COUNT + 10) @(negedge clk);
    $display("Checked %0d events over %0d register settings: %0d assigned, %0d spilled,",
             results_seen, cfg_settings, status_hits[ST_ASSIGNED],
             status_hits[ST_SPILL_ASSIGNED]);
    $display("%0d without a register, %0d ends, %0d ignored starts, %0d mismatches",
             status_hits[ST_NO_REG], status_hits[ST_END], status_hits[ST_IGNORED],
             mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- linear_scan_register_allocator.f -----
src/lsra_pkg.sv
src/lsra_ram.sv
src/lsra_ctrl.sv
src/linear_scan_register_allocator.sv
verif/tb_linear_scan_register_allocator.sv
